// File: hdl/fts_pkg.sv
// Shared types, codes and defaults for the time-search FIFO queue.
package fts_pkg;

   localparam int DEPTH_DEF     = 64;
   localparam int ITEM_BITS_DEF = 16;
   localparam int TIME_BITS_DEF = 32;

   typedef enum logic [2:0] {
      FUNC_INSERT      = 3'd0,
      FUNC_DELETE      = 3'd1,
      FUNC_FIND_ITEM   = 3'd2,
      FUNC_FIND_TIME   = 3'd3,
      FUNC_COUNT_ALL   = 3'd4,
      FUNC_COUNT_AFTER = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DEL_WAIT,
      S_SCAN,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic ins;
      logic full_drop;
      logic empty_rpt;
      logic del_take;
      logic scan_run;
      logic scan_miss;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] func;
      logic       empty;
      logic       full;
      logic       hit;
      logic       last;
   } stat_type;

endpackage

// File: hdl/fts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fts_ctrl.sv
// Request sequencer: decodes a beat, runs the head-to-tail scan, issues the result.
module fts_ctrl import fts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   state_type state_ff, state_in;
   logic      is_find;

   assign is_find = stat.func inside {FUNC_FIND_ITEM, FUNC_FIND_TIME};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_DELETE:
                  state_in = stat.empty ? S_RESP : S_DEL_WAIT;
               FUNC_FIND_ITEM, FUNC_FIND_TIME, FUNC_COUNT_AFTER:
                  state_in = stat.empty ? S_RESP : S_SCAN;
               default:
                  state_in = S_RESP;
            endcase
         end
         S_DEL_WAIT: state_in = S_RESP;
         S_SCAN: begin
            if ((is_find && stat.hit) || stat.last) state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_INSERT: begin
                  cmd.full_drop = stat.full;
                  cmd.ins       = !stat.full;
               end
               FUNC_DELETE, FUNC_FIND_ITEM, FUNC_FIND_TIME: begin
                  cmd.empty_rpt = stat.empty;
               end
               default: ;
            endcase
         end
         S_DEL_WAIT: cmd.del_take = 1'b1;
         S_SCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_miss = is_find && stat.last && !stat.hit;
         end
         S_RESP:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// File: hdl/fts_datapath.sv
// Queue pointers, counters, entry RAM, scan compare and result registers.
module fts_datapath import fts_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF,
   parameter int AW        = $clog2(DEPTH),
   parameter int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [2:0]           req_func,
   input  logic [ITEM_BITS-1:0] req_item_value,
   input  logic [TIME_BITS-1:0] req_time_value,
   output logic [1:0]           rsp_status,
   output logic [AW-1:0]        rsp_found_position,
   output logic [ITEM_BITS-1:0] rsp_found_item,
   output logic [TIME_BITS-1:0] rsp_found_time,
   output logic [CNT_W-1:0]     rsp_result_count,
   output logic [31:0]          rsp_departures
);

   localparam int ENTRY_W = ITEM_BITS + TIME_BITS;

   logic [2:0]           func_ff, func_in;
   logic [ITEM_BITS-1:0] item_ff, item_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [AW-1:0]        head_ff, head_in, tail_ff, tail_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     occ_ff, occ_in, ic_ff, ic_in, hits_ff, hits_in;
   logic [31:0]          dep_ff, dep_in;
   logic                 dv_ff, dv_in;
   logic [AW-1:0]        chk_ff, chk_in, pos_ff, pos_in;
   status_type           st_ff, st_in;
   logic [ITEM_BITS-1:0] fitem_ff, fitem_in;
   logic [TIME_BITS-1:0] ftime_ff, ftime_in;

   logic [ENTRY_W-1:0]   rd_data;
   logic [ITEM_BITS-1:0] rd_item;
   logic [TIME_BITS-1:0] rd_time;
   logic                 match, hit, issue;

   fts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ins),
      .wr_addr (tail_ff),
      .wr_data ({item_ff, time_ff}),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign rd_item = rd_data[ENTRY_W-1:TIME_BITS];
   assign rd_time = rd_data[TIME_BITS-1:0];
   assign match   = (func_ff == FUNC_FIND_ITEM) ? (rd_item == item_ff) : (rd_time >= time_ff);
   assign hit     = dv_ff && match;
   assign issue   = ic_ff < occ_ff;

   assign stat.func  = func_ff;
   assign stat.empty = (occ_ff == '0);
   assign stat.full  = (occ_ff == CNT_W'(DEPTH));
   assign stat.hit   = hit;
   assign stat.last  = dv_ff && (CNT_W'(chk_ff) == occ_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         dep_ff  <= '0;
         dv_ff   <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         dep_ff  <= dep_in;
         dv_ff   <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      item_ff   <= item_in;
      time_ff   <= time_in;
      rd_ptr_ff <= rd_ptr_in;
      ic_ff     <= ic_in;
      hits_ff   <= hits_in;
      chk_ff    <= chk_in;
      pos_ff    <= pos_in;
      st_ff     <= st_in;
      fitem_ff  <= fitem_in;
      ftime_ff  <= ftime_in;
   end

   always_comb begin
      func_in   = func_ff;
      item_in   = item_ff;
      time_in   = time_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      dep_in    = dep_ff;
      rd_ptr_in = rd_ptr_ff;
      ic_in     = ic_ff;
      dv_in     = dv_ff;
      chk_in    = chk_ff;
      hits_in   = hits_ff;
      pos_in    = pos_ff;
      st_in     = st_ff;
      fitem_in  = fitem_ff;
      ftime_in  = ftime_ff;

      if (cmd.load) begin
         func_in   = req_func;
         item_in   = req_item_value;
         time_in   = req_time_value;
         rd_ptr_in = head_ff;   // also reads the head for a delete
         ic_in     = '0;
         dv_in     = 1'b0;
         hits_in   = '0;
         pos_in    = '0;
         st_in     = ST_OK;
         fitem_in  = '0;
         ftime_in  = '0;
      end
      if (cmd.ins) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         occ_in  = occ_ff + 1'b1;
      end
      if (cmd.full_drop) st_in = ST_FULL;
      if (cmd.empty_rpt) st_in = ST_EMPTY;
      if (cmd.scan_miss) st_in = ST_NOT_FOUND;
      if (cmd.del_take) begin
         fitem_in = rd_item;
         ftime_in = rd_time;
         head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         occ_in   = occ_ff - 1'b1;
         dep_in   = dep_ff + 1'b1;
      end
      if (cmd.scan_run) begin
         // read issue runs ahead of the compare, which sees the entry through the registered RAM read
         dv_in = issue;
         if (issue) begin
            rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            ic_in     = ic_ff + 1'b1;
            chk_in    = ic_ff[AW-1:0];
         end
         if (hit && (func_ff inside {FUNC_FIND_ITEM, FUNC_FIND_TIME})) begin
            pos_in   = chk_ff;
            fitem_in = rd_item;
            ftime_in = rd_time;
         end
         if (hit && (func_ff == FUNC_COUNT_AFTER)) hits_in = hits_ff + 1'b1;
      end
   end

   assign rsp_status         = st_ff;
   assign rsp_found_position = pos_ff;
   assign rsp_found_item     = fitem_ff;
   assign rsp_found_time     = ftime_ff;
   assign rsp_result_count   = (func_ff == FUNC_COUNT_AFTER) ? hits_ff : occ_ff;
   assign rsp_departures     = dep_ff;

endmodule

// File: hdl/fifo_time_search_queue.sv
// Top level: bounded FIFO of (item, time) entries with search and count requests.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  request | req_func, req_item_value, req_time_value | beat taken when start && !busy
//  result  | rsp_status .. rsp_departures            | rsp_valid high one cycle
//
//  For insert, count-all and unused codes the result beat follows the decode state; a
//  delete that finds an entry also passes a read-wait state. Find and count-after walk the
//  entries from the head through the single RAM read port, one per cycle.
//  busy drops the cycle after the result strobe, so one beat is in flight at a time.
//  Synchronous reset empties the queue and clears the departure count; entry
//  contents are not cleared. Results cannot be stalled.
module fifo_time_search_queue import fts_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_func,
   input  logic [ITEM_BITS-1:0]           req_item_value,
   input  logic [TIME_BITS-1:0]           req_time_value,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [$clog2(DEPTH)-1:0]       rsp_found_position,
   output logic [ITEM_BITS-1:0]           rsp_found_item,
   output logic [TIME_BITS-1:0]           rsp_found_time,
   output logic [$clog2(DEPTH + 1)-1:0]   rsp_result_count,
   output logic [31:0]                    rsp_departures
);

   cmd_type  cmd;
   stat_type stat;

   fts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fts_datapath #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_item_value     (req_item_value),
      .req_time_value     (req_time_value),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found_item     (rsp_found_item),
      .rsp_found_time     (rsp_found_time),
      .rsp_result_count   (rsp_result_count),
      .rsp_departures     (rsp_departures)
   );

endmodule

// File: hdl/fts_checker.sv
// Port-level checks for the time-search FIFO queue, bound to the top level.
module fts_checker import fts_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [1:0]                   rsp_status,
   input logic [$clog2(DEPTH + 1)-1:0] rsp_result_count,
   input logic [31:0]                  rsp_departures
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // an accepted beat holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted beat");

   // a result is never repeated, and the block frees up after it
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result not followed by idle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a busy period");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_result_count == CNT_W'(DEPTH)))
      else $error("full status without full occupancy");

   // departures only move across a beat
   a_dep_stable: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start && !$past(reset)) |=> $stable(rsp_departures))
      else $error("departure count changed while idle");

endmodule

bind fifo_time_search_queue fts_checker #(
   .DEPTH     (DEPTH),
   .ITEM_BITS (ITEM_BITS),
   .TIME_BITS (TIME_BITS)
) u_fts_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_result_count (rsp_result_count),
   .rsp_departures   (rsp_departures)
);

// File: tb/tb_fifo_time_search_queue.sv
// Testbench for fifo_time_search_queue: directed table, then random bursts checked by a predictor.
module tb_fifo_time_search_queue import fts_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_W = ITEM_BITS_DEF;
   localparam int TIME_W = TIME_BITS_DEF;
   localparam int POS_W  = $clog2(DEPTH_DEF);
   localparam int CNT_W  = $clog2(DEPTH_DEF + 1);

   // codes the block treats as count-all
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   localparam int BURST_FILL  = 0;
   localparam int BURST_DRAIN = 1;
   localparam int BURST_MIX   = 2;

   localparam int DIR_ROWS   = 25;
   localparam int RAND_ITEMS = 1350;
   localparam int ALL_ITEMS  = DIR_ROWS + RAND_ITEMS;

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    pos;
      logic [ITEM_W-1:0]   item;
      logic [TIME_W-1:0]   tval;
      logic [CNT_W-1:0]    count;
      logic [31:0]         departs;
   } queue_reply_type;

   typedef struct packed {
      logic [2:0]          func;
      logic [ITEM_W-1:0]   item;
      logic [TIME_W-1:0]   tval;
      logic                typed;
      queue_reply_type     want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_func = FUNC_COUNT_ALL;
   logic [ITEM_W-1:0]   req_item_value = '0;
   logic [TIME_W-1:0]   req_time_value = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [POS_W-1:0]    rsp_found_position;
   logic [ITEM_W-1:0]   rsp_found_item;
   logic [TIME_W-1:0]   rsp_found_time;
   logic [CNT_W-1:0]    rsp_result_count;
   logic [31:0]         rsp_departures;

   // predictor state
   logic [ITEM_W-1:0]   q_item [DEPTH_DEF];
   logic [TIME_W-1:0]   q_time [DEPTH_DEF];
   int                  q_head = 0;
   int                  q_tail = 0;
   int                  q_occ  = 0;
   logic [31:0]         q_departs = '0;

   queue_reply_type     pending_replies [$];
   int                  beats_sent = 0;
   int                  bad_replies = 0;
   int                  idle_pct = 10;
   logic [TIME_W-1:0]   tick_now = '0;

   // directed rows; all expectations follow from an empty queue after reset
   dir_row_type dir_table [DIR_ROWS] = '{
      '{FUNC_DELETE,      16'h0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY,     6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_FIND_ITEM,   16'h0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY,     6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_FIND_TIME,   16'hFFFF, 32'h0000_0000, 1'b1,
        '{ST_EMPTY,     6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_COUNT_ALL,   16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_COUNT_AFTER, 16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_SPARE_6,     16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd0}},
      '{FUNC_INSERT,      16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd1, 32'd0}},
      '{FUNC_INSERT,      16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd2, 32'd0}},
      '{FUNC_INSERT,      16'h8000, 32'h8000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd3, 32'd0}},
      '{FUNC_FIND_ITEM,   16'h0000, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd1, 16'h0000, 32'h0000_0000, 7'd3, 32'd0}},
      '{FUNC_FIND_ITEM,   16'h1234, 32'h0000_0000, 1'b1,
        '{ST_NOT_FOUND, 6'd0, 16'h0000, 32'h0000_0000, 7'd3, 32'd0}},
      '{FUNC_FIND_ITEM,   16'h8000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd2, 16'h8000, 32'h8000_0000, 7'd3, 32'd0}},
      '{FUNC_FIND_TIME,   16'h0000, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd0, 16'hFFFF, 32'hFFFF_FFFF, 7'd3, 32'd0}},
      '{FUNC_FIND_TIME,   16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'hFFFF, 32'hFFFF_FFFF, 7'd3, 32'd0}},
      '{FUNC_COUNT_AFTER, 16'hFFFF, 32'h0000_0001, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd2, 32'd0}},
      '{FUNC_COUNT_AFTER, 16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd3, 32'd0}},
      '{FUNC_COUNT_AFTER, 16'h0000, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd1, 32'd0}},
      '{FUNC_SPARE_7,     16'h0001, 32'h0000_0001, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd3, 32'd0}},
      '{FUNC_DELETE,      16'h5A5A, 32'hA5A5_A5A5, 1'b1,
        '{ST_OK,        6'd0, 16'hFFFF, 32'hFFFF_FFFF, 7'd2, 32'd1}},
      '{FUNC_FIND_TIME,   16'h0000, 32'h0000_0001, 1'b1,
        '{ST_OK,        6'd1, 16'h8000, 32'h8000_0000, 7'd2, 32'd1}},
      '{FUNC_FIND_TIME,   16'h0000, 32'h8000_0001, 1'b1,
        '{ST_NOT_FOUND, 6'd0, 16'h0000, 32'h0000_0000, 7'd2, 32'd1}},
      '{FUNC_DELETE,      16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd1, 32'd2}},
      '{FUNC_DELETE,      16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h8000, 32'h8000_0000, 7'd0, 32'd3}},
      '{FUNC_DELETE,      16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_EMPTY,     6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd3}},
      '{FUNC_COUNT_ALL,   16'h0000, 32'h0000_0000, 1'b1,
        '{ST_OK,        6'd0, 16'h0000, 32'h0000_0000, 7'd0, 32'd3}}
   };

   fifo_time_search_queue u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_item_value     (req_item_value),
      .req_time_value     (req_time_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found_item     (rsp_found_item),
      .rsp_found_time     (rsp_found_time),
      .rsp_result_count   (rsp_result_count),
      .rsp_departures     (rsp_departures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one request to the queue image and returns the reply it causes
   function automatic queue_reply_type queue_apply(input logic [2:0] f,
                                                   input logic [ITEM_W-1:0] it,
                                                   input logic [TIME_W-1:0] tv);
      queue_reply_type r;
      int idx;
      int k;
      int hits;
      bit hit;
      logic match;
      r = '0;
      r.status = ST_OK;
      hits = 0;
      hit = 1'b0;
      case (f)
         FUNC_INSERT: begin
            if (q_occ >= DEPTH_DEF) begin
               r.status = ST_FULL;
            end else begin
               q_item[q_tail] = it;
               q_time[q_tail] = tv;
               q_tail = (q_tail + 1) % DEPTH_DEF;
               q_occ++;
            end
         end
         FUNC_DELETE: begin
            if (q_occ == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.item = q_item[q_head];
               r.tval = q_time[q_head];
               q_head = (q_head + 1) % DEPTH_DEF;
               q_occ--;
               q_departs = q_departs + 32'd1;
            end
         end
         FUNC_FIND_ITEM, FUNC_FIND_TIME: begin
            if (q_occ == 0) begin
               r.status = ST_EMPTY;
            end else begin
               idx = q_head;
               for (k = 0; k < q_occ && !hit; k++) begin
                  match = (f == FUNC_FIND_ITEM) ? (q_item[idx] == it) : (q_time[idx] >= tv);
                  if (match) begin
                     hit = 1'b1;
                     r.pos = POS_W'(k);
                     r.item = q_item[idx];
                     r.tval = q_time[idx];
                  end
                  idx = (idx + 1) % DEPTH_DEF;
               end
               if (!hit) r.status = ST_NOT_FOUND;
            end
         end
         FUNC_COUNT_AFTER: begin
            idx = q_head;
            for (k = 0; k < q_occ; k++) begin
               if (q_time[idx] >= tv) hits++;
               idx = (idx + 1) % DEPTH_DEF;
            end
         end
         default: ;
      endcase
      r.count = (f == FUNC_COUNT_AFTER) ? CNT_W'(hits) : CNT_W'(q_occ);
      r.departs = q_departs;
      return r;
   endfunction

   // one request beat; start stays high into the next beat when no gap follows
   task automatic send_request(input logic [2:0] f, input logic [ITEM_W-1:0] it,
                               input logic [TIME_W-1:0] tv, input logic typed,
                               input queue_reply_type want);
      int gap;
      queue_reply_type got;
      idle_pct = (beats_sent < ALL_ITEMS / 3) ? 10 : (beats_sent < 2 * ALL_ITEMS / 3) ? 68 : 0;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_item_value <= it;
      req_time_value <= tv;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = queue_apply(f, it, tv);
      pending_replies.push_back(typed ? want : got);
      beats_sent++;
   endtask

   task automatic pick_request(input int mode, output logic [2:0] f,
                               output logic [ITEM_W-1:0] it, output logic [TIME_W-1:0] tv);
      int w_ins;
      int w_del;
      int roll;
      int at;
      int sel;
      case (mode)
         BURST_FILL:  begin w_ins = 85; w_del = 5;  end
         BURST_DRAIN: begin w_ins = 15; w_del = 65; end
         default:     begin w_ins = 30; w_del = 20; end
      endcase
      roll = $urandom_range(99);
      if (roll < w_ins) begin
         f = FUNC_INSERT;
      end else if (roll < w_ins + w_del) begin
         f = FUNC_DELETE;
      end else begin
         sel = $urandom_range(99);
         if (sel < 35)      f = FUNC_FIND_ITEM;
         else if (sel < 65) f = FUNC_FIND_TIME;
         else if (sel < 85) f = FUNC_COUNT_AFTER;
         else if (sel < 95) f = FUNC_COUNT_ALL;
         else               f = $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end
      // small item pool so searches hit duplicates
      it = ($urandom_range(99) < 50) ? ITEM_W'($urandom_range(15)) : ITEM_W'($urandom);
      tv = TIME_W'($urandom);
      at = (q_occ > 0) ? (q_head + $urandom_range(q_occ - 1)) % DEPTH_DEF : 0;
      sel = $urandom_range(99);
      case (f)
         FUNC_INSERT: begin
            if (sel < 60) begin
               tick_now = tick_now + TIME_W'($urandom_range(1000));
               tv = tick_now;
            end else if (sel < 70) begin
               tv = $urandom_range(1) ? '1 : '0;
            end
         end
         FUNC_FIND_ITEM: begin
            if (q_occ > 0 && sel < 65) it = q_item[at];
         end
         FUNC_FIND_TIME, FUNC_COUNT_AFTER: begin
            if (q_occ > 0 && sel < 55)
               tv = q_time[at] + TIME_W'($urandom_range(2)) - TIME_W'(1);
            else if (sel < 70)
               tv = $urandom_range(1) ? '1 : '0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            if (bad_replies < 10)
               $display("%0t: result beat with nothing pending", $realtime);
            bad_replies++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_found_position !== want.pos ||
                rsp_found_item !== want.item || rsp_found_time !== want.tval ||
                rsp_result_count !== want.count || rsp_departures !== want.departs) begin
               if (bad_replies < 10) begin
                  $display("%0t: exp st=%0d pos=%0d item=%h time=%h cnt=%0d dep=%0d",
                           $realtime, want.status, want.pos, want.item, want.tval,
                           want.count, want.departs);
                  $display("%0t: got st=%0d pos=%0d item=%h time=%h cnt=%0d dep=%0d",
                           $realtime, rsp_status, rsp_found_position, rsp_found_item,
                           rsp_found_time, rsp_result_count, rsp_departures);
               end
               bad_replies++;
            end
         end
      end
   end

   initial begin
      int row;
      int burst;
      int blen;
      int n;
      int mode;
      int rand_sent;
      logic [2:0] f;
      logic [ITEM_W-1:0] it;
      logic [TIME_W-1:0] tv;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (row = 0; row < DIR_ROWS; row++)
         send_request(dir_table[row].func, dir_table[row].item, dir_table[row].tval,
                      dir_table[row].typed, dir_table[row].want);
      // first burst is insert-heavy, to drive the queue toward full and past it
      rand_sent = 0;
      burst = 0;
      while (rand_sent < RAND_ITEMS) begin
         mode = (burst == 0) ? BURST_FILL : $urandom_range(BURST_MIX);
         blen = (burst == 0) ? 80 : $urandom_range(20, 80);
         for (n = 0; n < blen && rand_sent < RAND_ITEMS; n++) begin
            pick_request(mode, f, it, tv);
            send_request(f, it, tv, 1'b0, '0);
            rand_sent++;
         end
         burst++;
      end
      @(posedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (bad_replies == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
